/* design/page_frame_replacement_assert.svh */
// Assertion macros used by the page frame table checker
`ifndef PAGE_FRAME_REPLACEMENT_ASSERT_SVH
`define PAGE_FRAME_REPLACEMENT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PFR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pfr check failed: implication");

// signal holds in the next cycle while the condition stands
`define PFR_ASSERT_HOLD(lbl, clk, rstn, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> $stable(sig)) \
    else $error("pfr check failed: value not held");

`endif

/* design/pfr_pkg.sv */
`timescale 1ns / 1ps
package pfr_pkg;

  localparam int NUM_FRAMES = 16;
  localparam int FRAME_W    = 4;
  localparam int CNT_W      = 5;
  localparam int PID_W      = 8;
  localparam int VPAGE_W    = 12;
  localparam int MISS_W     = 16;

  // victim policy codes
  localparam logic POLICY_LRU   = 1'b0;
  localparam logic POLICY_CLOCK = 1'b1;

  // configuration register indexes
  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_FRAMES = 1'b1;

  typedef enum logic [1:0] {
    OP_ACCESS  = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_HIT_REF,
    CMD_HIT_LRU,
    CMD_LOAD,
    CMD_FREE,
    CMD_CLR_REF,
    CMD_CLEAR
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LRU,
    ST_CLK,
    ST_REL,
    ST_EVICT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [PID_W-1:0]   pid;
    logic [VPAGE_W-1:0] page_number;
  } in_word_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic               evicted;
    logic [PID_W-1:0]   victim_pid;
    logic [VPAGE_W-1:0] victim_page;
    logic [CNT_W-1:0]   freed_count;
    logic [MISS_W-1:0]  fault_count;
  } out_word_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    cmd_e               kind;
    logic [FRAME_W-1:0] tgt;
    logic               evict;
    logic [FRAME_W-1:0] rank;
    logic [CNT_W-1:0]   cnt;
    logic [PID_W-1:0]   pid;
    logic [VPAGE_W-1:0] vpage;
  } cell_cmd_t;

  // what one cell shows back
  typedef struct packed {
    logic               valid;
    logic               refb;
    logic [FRAME_W-1:0] rank;
    logic [PID_W-1:0]   owner;
    logic [VPAGE_W-1:0] vpage;
    logic               first_hit;
    logic               first_free;
  } cell_stat_t;

endpackage

/* design/pfr_cell.sv */
`timescale 1ns / 1ps
// One physical frame: tag, reference bit and recency rank.
module pfr_cell import pfr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [FRAME_W-1:0] idx_i,
  input  logic               in_range_i,
  input  cell_cmd_t          cmd_i,
  input  logic               hit_prev_i,
  input  logic               free_prev_i,
  output logic               hit_o,
  output logic               free_o,
  output cell_stat_t         stat_o
);

  logic               valid_q, valid_d;
  logic               ref_q, ref_d;
  logic [FRAME_W-1:0] rank_q, rank_d;
  logic [PID_W-1:0]   owner_q;
  logic [VPAGE_W-1:0] vpage_q;
  logic               self;
  logic               match;
  logic               empty;
  logic [FRAME_W-1:0] rank_f;

  assign self  = (idx_i == cmd_i.tgt);
  assign match = valid_q && (owner_q == cmd_i.pid) && (vpage_q == cmd_i.vpage);
  assign empty = !valid_q && in_range_i;

  // priority chains toward higher frames
  assign hit_o  = hit_prev_i | match;
  assign free_o = free_prev_i | empty;

  assign stat_o = '{valid: valid_q, refb: ref_q, rank: rank_q, owner: owner_q,
                    vpage: vpage_q, first_hit: match && !hit_prev_i,
                    first_free: empty && !free_prev_i};

  // rank after the victim left, for a load that evicts
  assign rank_f = (cmd_i.evict && (rank_q > cmd_i.rank)) ? rank_q - 1'b1 : rank_q;

  always_comb begin
    valid_d = valid_q;
    ref_d   = ref_q;
    rank_d  = rank_q;
    case (cmd_i.kind)
      CMD_HIT_REF: begin
        if (self) ref_d = 1'b1;
      end
      CMD_HIT_LRU: begin
        if (self) begin
          ref_d  = 1'b1;
          rank_d = '0;
        end else if (valid_q && (rank_q < cmd_i.rank)) begin
          rank_d = rank_q + 1'b1;
        end
      end
      CMD_LOAD: begin
        if (self) begin
          valid_d = 1'b1;
          ref_d   = 1'b1;
          rank_d  = '0;
        end else if (valid_q) begin
          rank_d = ({1'b0, rank_f} < cmd_i.cnt) ? rank_f + 1'b1 : rank_f;
        end
      end
      CMD_FREE: begin
        if (self) begin
          valid_d = 1'b0;
          ref_d   = 1'b0;
          rank_d  = '0;
        end else if (valid_q && (rank_q > cmd_i.rank)) begin
          rank_d = rank_q - 1'b1;
        end
      end
      CMD_CLR_REF: begin
        if (self) ref_d = 1'b0;
      end
      CMD_CLEAR: begin
        valid_d = 1'b0;
        ref_d   = 1'b0;
        rank_d  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ref_q   <= 1'b0;
      rank_q  <= '0;
    end else begin
      valid_q <= valid_d;
      ref_q   <= ref_d;
      rank_q  <= rank_d;
    end
  end

  // tag written on load
  always_ff @(posedge clk_i) begin
    if (cmd_i.kind == CMD_LOAD && self) begin
      owner_q <= cmd_i.pid;
      vpage_q <= cmd_i.vpage;
    end
  end

endmodule

/* design/page_frame_replacement.sv */
`timescale 1ns / 1ps
// Page frame table with LRU or clock replacement over a row of 16 frame cells.
// One word is taken at a time. An access that hits, or that finds a free frame,
// goes from the execute state straight to the result. A miss with the table full
// scans the frames one per cycle: LRU walks all active frames; clock moves the
// hand, clearing set reference bits, until it finds a frame whose bit is clear.
// A release walks all 16 frames; a clear needs no scan. The result
// is held until taken, and the next word is accepted only after that.
module page_frame_replacement import pfr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_word_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CNT_W-1:0]    cfg_data_i
);

  state_e             state_q, state_d;
  logic               policy_q;
  logic [CNT_W-1:0]   fiu_q;
  logic [CNT_W-1:0]   n_act;
  in_word_t           item_q;
  cell_cmd_t          cmd;
  cell_stat_t         stat [NUM_FRAMES];
  cell_stat_t         sel;
  logic [NUM_FRAMES:0] hit_chain, free_chain;
  logic [NUM_FRAMES-1:0] in_range;
  logic               hit_any, free_any;
  logic [FRAME_W-1:0] hit_idx, free_idx, sel_idx;
  logic [FRAME_W-1:0] hand_q, hand_wrap, ptr_q, vic_q, best_q, best_rank_q;
  logic [CNT_W-1:0]   hand_inc;
  logic               found_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [MISS_W-1:0]  miss_q;
  logic               lru_take, lru_last, rel_last, rel_match, clk_found;
  logic               res_hit_q, res_ev_q;
  logic [FRAME_W-1:0] res_frame_q;
  logic [PID_W-1:0]   res_vpid_q;
  logic [VPAGE_W-1:0] res_vpg_q;
  logic [CNT_W-1:0]   freed_q;
  logic [MISS_W-1:0]  miss_inc;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POLICY_LRU;
      fiu_q    <= CNT_W'(NUM_FRAMES);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POLICY: policy_q <= cfg_data_i[0];
        CFG_FRAMES: fiu_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp the frame count into 1..NUM_FRAMES
  always_comb begin
    if (fiu_q == '0) n_act = CNT_W'(1);
    else if (fiu_q > CNT_W'(NUM_FRAMES)) n_act = CNT_W'(NUM_FRAMES);
    else n_act = fiu_q;
  end

  // frame cells
  assign hit_chain[0]  = 1'b0;
  assign free_chain[0] = 1'b0;
  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    assign in_range[i] = (CNT_W'(i) < n_act);
    pfr_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (FRAME_W'(i)),
      .in_range_i  (in_range[i]),
      .cmd_i       (cmd),
      .hit_prev_i  (hit_chain[i]),
      .free_prev_i (free_chain[i]),
      .hit_o       (hit_chain[i+1]),
      .free_o      (free_chain[i+1]),
      .stat_o      (stat[i])
    );
  end

  assign hit_any  = hit_chain[NUM_FRAMES];
  assign free_any = free_chain[NUM_FRAMES];

  // encode first hit and first free frame
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (stat[i].first_hit)  hit_idx  = FRAME_W'(i);
      if (stat[i].first_free) free_idx = FRAME_W'(i);
    end
  end

  // one frame selected for inspection per cycle
  always_comb begin
    case (state_q)
      ST_LRU, ST_REL: sel_idx = ptr_q;
      ST_CLK:         sel_idx = hand_q;
      ST_EVICT:       sel_idx = vic_q;
      default:        sel_idx = hit_idx;
    endcase
  end
  assign sel = stat[sel_idx];

  assign hand_inc  = {1'b0, hand_q} + 1'b1;
  assign hand_wrap = (hand_inc >= n_act) ? '0 : hand_inc[FRAME_W-1:0];
  assign lru_take  = sel.valid && (!found_q || (sel.rank > best_rank_q));
  assign lru_last  = ({1'b0, ptr_q} == n_act - 1'b1);
  assign rel_last  = (ptr_q == FRAME_W'(NUM_FRAMES - 1));
  assign rel_match = sel.valid && (sel.owner == item_q.pid);
  assign clk_found = sel.valid && !sel.refb;
  assign miss_inc  = (miss_q == '1) ? miss_q : miss_q + 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: begin
        case (item_q.operation)
          OP_ACCESS: begin
            if (hit_any || free_any) state_d = ST_RESP;
            else if (policy_q == POLICY_LRU) state_d = ST_LRU;
            else state_d = ST_CLK;
          end
          OP_RELEASE: state_d = ST_REL;
          default:    state_d = ST_RESP;
        endcase
      end
      ST_LRU:   if (lru_last) state_d = ST_EVICT;
      ST_CLK:   if (clk_found) state_d = ST_EVICT;
      ST_REL:   if (rel_last) state_d = ST_RESP;
      ST_EVICT: state_d = ST_RESP;
      ST_RESP:  if (out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // cell command and handshake outputs
  always_comb begin
    cmd       = '0;
    cmd.kind  = CMD_IDLE;
    cmd.pid   = item_q.pid;
    cmd.vpage = item_q.page_number;
    case (state_q)
      ST_EXEC: begin
        if (item_q.operation == OP_ACCESS) begin
          if (hit_any) begin
            cmd.kind = (policy_q == POLICY_LRU) ? CMD_HIT_LRU : CMD_HIT_REF;
            cmd.tgt  = hit_idx;
            cmd.rank = sel.rank;
          end else if (free_any) begin
            cmd.kind = CMD_LOAD;
            cmd.tgt  = free_idx;
            cmd.cnt  = cnt_q;
          end
        end else if (item_q.operation == OP_CLEAR) begin
          cmd.kind = CMD_CLEAR;
        end
      end
      ST_CLK: begin
        if (!clk_found) begin
          cmd.kind = CMD_CLR_REF;
          cmd.tgt  = hand_q;
        end
      end
      ST_REL: begin
        if (rel_match) begin
          cmd.kind = CMD_FREE;
          cmd.tgt  = ptr_q;
          cmd.rank = sel.rank;
        end
      end
      ST_EVICT: begin
        cmd.kind  = CMD_LOAD;
        cmd.tgt   = vic_q;
        cmd.evict = 1'b1;
        cmd.rank  = sel.rank;
        cmd.cnt   = cnt_q - 1'b1;
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_RESP);
  assign out_data_o  = '{hit: res_hit_q, frame: res_frame_q, evicted: res_ev_q,
                         victim_pid: res_vpid_q, victim_page: res_vpg_q,
                         freed_count: freed_q, fault_count: miss_q};

  // control state: sequencer, hand, counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hand_q  <= '0;
      cnt_q   <= '0;
      miss_q  <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_EXEC: begin
          if (item_q.operation == OP_ACCESS && !hit_any) begin
            if (free_any) begin
              cnt_q  <= cnt_q + 1'b1;
              miss_q <= miss_inc;
            end else if (policy_q == POLICY_CLOCK && {1'b0, hand_q} >= n_act) begin
              hand_q <= '0;
            end
          end else if (item_q.operation == OP_CLEAR) begin
            cnt_q  <= '0;
            miss_q <= '0;
          end
        end
        ST_CLK:   hand_q <= hand_wrap;
        ST_REL:   if (rel_match) cnt_q <= cnt_q - 1'b1;
        ST_EVICT: miss_q <= miss_inc;
        default: ;
      endcase
    end
  end

  // word and result registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_q      <= in_data_i;
          res_hit_q   <= 1'b0;
          res_ev_q    <= 1'b0;
          res_frame_q <= '0;
          res_vpid_q  <= '0;
          res_vpg_q   <= '0;
          freed_q     <= '0;
          ptr_q       <= '0;
          found_q     <= 1'b0;
        end
      end
      ST_EXEC: begin
        if (item_q.operation == OP_ACCESS) begin
          if (hit_any) begin
            res_hit_q   <= 1'b1;
            res_frame_q <= hit_idx;
          end else if (free_any) begin
            res_frame_q <= free_idx;
          end
        end else if (item_q.operation == OP_CLEAR) begin
          freed_q <= cnt_q;
        end
      end
      ST_LRU: begin
        if (lru_take) begin
          best_q      <= ptr_q;
          best_rank_q <= sel.rank;
          found_q     <= 1'b1;
        end
        if (lru_last) vic_q <= lru_take ? ptr_q : best_q;
        ptr_q <= ptr_q + 1'b1;
      end
      ST_CLK: begin
        if (clk_found) vic_q <= hand_q;
      end
      ST_REL: begin
        if (rel_match) freed_q <= freed_q + 1'b1;
        ptr_q <= ptr_q + 1'b1;
      end
      ST_EVICT: begin
        res_frame_q <= vic_q;
        res_ev_q    <= 1'b1;
        res_vpid_q  <= sel.owner;
        res_vpg_q   <= sel.vpage;
      end
      default: ;
    endcase
  end

endmodule

/* design/pfr_checker.sv */
`timescale 1ns / 1ps
`include "page_frame_replacement_assert.svh"
// Port-level checks on the page frame table.
module pfr_checker import pfr_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input out_word_t        out_data_o
);

  // a stalled result word holds
  `PFR_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_data_o)

  // one word in flight: no intake while a result waits
  `PFR_ASSERT_IMPL(a_one_word, clk_i, rst_ni, out_valid_o, !in_ready_o)

  // a hit never evicts and frees nothing
  `PFR_ASSERT_IMPL(a_hit_clean, clk_i, rst_ni, out_valid_o && out_data_o.hit,
                   !out_data_o.evicted && out_data_o.freed_count == '0)

  // freed frames never exceed the table and exclude access fields
  `PFR_ASSERT_IMPL(a_freed_clean, clk_i, rst_ni,
                   out_valid_o && out_data_o.freed_count != '0,
                   out_data_o.freed_count <= CNT_W'(NUM_FRAMES) && !out_data_o.evicted &&
                   out_data_o.frame == '0)

endmodule

bind page_frame_replacement pfr_checker u_pfr_checker (.*);
